// File: sv/tkh_pkg.sv
// Shared types and constants of the top-k min-heap selector.
`default_nettype none

package tkh_pkg;

	localparam int KLIM_W = 7;
	localparam logic [KLIM_W-1:0] KLIM_RESET = 7'd16;
	localparam int DATA_W = 64;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic {
		OP_PUSH    = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	// doc id in the low half, score in the high half
	typedef struct packed {
		logic signed [31:0] score;
		logic [31:0]        doc;
	} entry_t;

	typedef struct packed {
		op_t    op;
		entry_t ent;
	} cmd_t;

	typedef struct packed {
		logic   present;
		logic   last;
		entry_t ent;
	} res_t;

endpackage

`default_nettype wire

// File: sv/tkh_ram.sv
// Generic RAM: one write port, registered read ports.
`default_nettype none

module tkh_ram #(
	parameter int WIDTH    = 64,
	parameter int DEPTH    = 16,
	parameter int RD_PORTS = 1,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr [RD_PORTS],
	output logic      [WIDTH-1:0] rdata [RD_PORTS]
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	for (genvar p = 0; p < RD_PORTS; p++) begin : g_rd
		always_ff @(posedge clk) begin
			rdata[p] <= mem_q[raddr[p]];
		end
	end

endmodule

`default_nettype wire

// File: sv/tkh_queue.sv
// Short command queue between the front and the heap engine.
`default_nettype none

module tkh_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tkh_pkg::cmd_t in_cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tkh_pkg::cmd_t      out_cmd
);

	import tkh_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_cmd   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

`default_nettype wire

// File: sv/tkh_front.sv
// Input stage: takes stream beats and decodes them into heap commands.
`default_nettype none

module tkh_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [tkh_pkg::DATA_W-1:0]  s_tdata,
	input  wire logic                        s_tuser,
	output logic                             cmd_valid,
	input  wire logic                        cmd_ready,
	output tkh_pkg::cmd_t                    cmd
);

	import tkh_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;

	assign s_tready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.op  <= s_tuser ? OP_EXTRACT : OP_PUSH;
			cmd_s1.ent <= entry_t'(s_tdata);
		end
	end

endmodule

`default_nettype wire

// File: sv/tkh_engine.sv
// Heap engine: sift up/down over the heap RAM, drain and emit results.
`default_nettype none

module tkh_engine #(
	parameter int CAPACITY = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tkh_pkg::KLIM_W-1:0]  cfg_data,
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire tkh_pkg::cmd_t               cmd,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output tkh_pkg::res_t                    res
);

	import tkh_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;
	localparam logic [KLIM_W-1:0] CAP_K = KLIM_W'(CAPACITY);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SU_STEP,
		ST_SU_EVAL,
		ST_ROOT_READ,
		ST_ROOT_EVAL,
		ST_SD_STEP,
		ST_SD_EVAL,
		ST_POP_READ,
		ST_POP_TAKE,
		ST_EM_READ,
		ST_EM_LOAD,
		ST_EMPTY
	} state_t;

	state_t              state_q;
	logic [KLIM_W-1:0]   k_limit_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       n_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       e_q;
	entry_t              item_q;
	op_t                 mode_q;
	logic                res_valid_q;
	res_t                res_q;

	// heap RAM: port 0 left child / parent / root, port 1 right child / tail
	logic                heap_we;
	logic [DATA_W-1:0]   heap_wdata;
	logic [AW-1:0]       heap_raddr [2];
	logic [DATA_W-1:0]   heap_rdata [2];
	logic                sort_we;
	logic [AW-1:0]       sort_raddr [1];
	logic [DATA_W-1:0]   sort_rdata [1];

	logic [KLIM_W-1:0]   k_eff;
	logic [AW-1:0]       pos_m1;
	logic [AW-1:0]       parent_idx;
	logic [IW-1:0]       l_ext;
	logic [IW-1:0]       r_ext;
	logic [IW-1:0]       size_ext;
	logic                l_in;
	logic                r_in;
	entry_t              rd0;
	entry_t              rd1;
	entry_t              best_l;
	logic                pick_l;
	logic                pick_r;
	logic                su_move;
	logic                out_free;
	logic                res_load;
	state_t              after_sd;

	tkh_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY), .RD_PORTS(2)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (pos_q),
		.wdata (heap_wdata),
		.raddr (heap_raddr),
		.rdata (heap_rdata)
	);

	tkh_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY), .RD_PORTS(1)) u_sort_ram (
		.clk   (clk),
		.we    (sort_we),
		.waddr (AW'(n_q)),
		.wdata (heap_rdata[0]),
		.raddr (sort_raddr),
		.rdata (sort_rdata)
	);

	assign k_eff      = (k_limit_q > CAP_K) ? CAP_K : k_limit_q;
	assign pos_m1     = pos_q - AW'(1);
	assign parent_idx = pos_m1 >> 1;
	assign l_ext      = {1'b0, pos_q, 1'b1};
	assign r_ext      = l_ext + IW'(1);
	assign size_ext   = IW'(count_q);
	assign l_in       = (l_ext < size_ext);
	assign r_in       = (r_ext < size_ext);
	assign rd0        = entry_t'(heap_rdata[0]);
	assign rd1        = entry_t'(heap_rdata[1]);
	assign su_move    = (item_q.score < rd0.score);
	assign pick_l     = l_in && (rd0.score < item_q.score);
	assign best_l     = pick_l ? rd0 : item_q;
	assign pick_r     = r_in && (rd1.score < best_l.score);
	assign out_free   = !res_valid_q || res_ready;
	assign res_load   = ((state_q == ST_EM_LOAD) || (state_q == ST_EMPTY)) && out_free;
	assign after_sd   = (mode_q == OP_EXTRACT) ?
		((count_q != '0) ? ST_POP_READ : ST_EM_READ) : ST_IDLE;

	assign cmd_ready     = (state_q == ST_IDLE);
	assign res_valid     = res_valid_q;
	assign res           = res_q;
	assign sort_we       = (state_q == ST_POP_TAKE);
	assign sort_raddr[0] = e_q;
	assign heap_raddr[1] = (state_q == ST_POP_READ) ? AW'(count_q - CW'(1)) : r_ext[AW-1:0];

	always_comb begin
		heap_raddr[0] = '0;
		heap_we       = 1'b0;
		heap_wdata    = item_q;
		unique case (state_q)
			ST_SU_STEP: begin
				heap_raddr[0] = parent_idx;
				heap_we       = (pos_q == '0);
			end
			ST_SU_EVAL: begin
				heap_we    = 1'b1;
				heap_wdata = su_move ? rd0 : item_q;
			end
			ST_SD_STEP: begin
				heap_raddr[0] = l_ext[AW-1:0];
				heap_we       = !l_in;
			end
			ST_SD_EVAL: begin
				heap_we    = 1'b1;
				heap_wdata = pick_r ? rd1 : best_l;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_limit_q   <= KLIM_RESET;
			count_q     <= '0;
			n_q         <= '0;
			mode_q      <= OP_PUSH;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				k_limit_q <= cfg_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						mode_q <= cmd.op;
						item_q <= cmd.ent;
						if (cmd.op == OP_EXTRACT) begin
							n_q     <= '0;
							state_q <= (count_q == '0) ? ST_EMPTY : ST_POP_READ;
						end else if (KLIM_W'(count_q) < k_eff) begin
							pos_q   <= AW'(count_q);
							count_q <= count_q + CW'(1);
							state_q <= ST_SU_STEP;
						end else if (count_q != '0) begin
							state_q <= ST_ROOT_READ;
						end
					end
				end
				ST_SU_STEP: begin
					state_q <= (pos_q == '0) ? ST_IDLE : ST_SU_EVAL;
				end
				ST_SU_EVAL: begin
					if (su_move) begin
						pos_q   <= parent_idx;
						state_q <= ST_SU_STEP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ROOT_READ: begin
					state_q <= ST_ROOT_EVAL;
				end
				ST_ROOT_EVAL: begin
					if (rd0.score < item_q.score) begin
						pos_q   <= '0;
						state_q <= ST_SD_STEP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SD_STEP: begin
					if (!l_in) begin
						e_q     <= AW'(n_q - CW'(1));
						state_q <= after_sd;
					end else begin
						state_q <= ST_SD_EVAL;
					end
				end
				ST_SD_EVAL: begin
					if (pick_r) begin
						pos_q   <= r_ext[AW-1:0];
						state_q <= ST_SD_STEP;
					end else if (pick_l) begin
						pos_q   <= l_ext[AW-1:0];
						state_q <= ST_SD_STEP;
					end else begin
						e_q     <= AW'(n_q - CW'(1));
						state_q <= after_sd;
					end
				end
				ST_POP_READ: begin
					state_q <= ST_POP_TAKE;
				end
				ST_POP_TAKE: begin
					item_q  <= rd1;
					count_q <= count_q - CW'(1);
					n_q     <= n_q + CW'(1);
					pos_q   <= '0;
					state_q <= ST_SD_STEP;
				end
				ST_EM_READ: begin
					state_q <= ST_EM_LOAD;
				end
				ST_EM_LOAD: begin
					if (out_free) begin
						res_q.present <= 1'b1;
						res_q.last    <= (e_q == '0);
						res_q.ent     <= entry_t'(sort_rdata[0]);
						if (e_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							e_q     <= e_q - AW'(1);
							state_q <= ST_EM_READ;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						res_q.present <= 1'b0;
						res_q.last    <= 1'b1;
						res_q.ent     <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP_TAKE |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not shrink the heap by one");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EM_READ |-> (count_q == '0) && (n_q != '0))
		else $error("emit started with a non-empty heap or nothing sorted");

	a_su_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SU_STEP || state_q == ST_SU_EVAL) |-> IW'(pos_q) < IW'(count_q))
		else $error("sift-up hole outside the heap");

	a_absent_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.present |-> res_q.last)
		else $error("empty-heap result without last");
`endif

endmodule

`default_nettype wire

// File: sv/top_k_min_heap_selector.sv
// Top level of the top-k min-heap selector: front stage, command queue, heap engine.
//
// Keeps the K best (doc id, score) pairs; K = min(k_limit, CAPACITY).
// Input channel s_*: one beat per command. s_tuser = 0 pushes the pair in
// s_tdata, s_tuser = 1 extracts everything. A push gives no output beat.
// An extract gives the kept entries on m_* in descending score order with
// m_tlast on the final beat and empties the heap; on an empty heap it gives
// one beat with m_tuser = 0, zero data and m_tlast = 1.
// Timing: an input beat passes a register stage and a 4-deep queue, so up to
// five beats are taken while the engine is busy. A push does one heap RAM
// read and write per level in the engine (levels = log2(CAPACITY)); a replace
// of the root adds a root read. An extract drains the heap into the sort
// buffer, then reads each output beat back from it.
// If m_tready is low the output register holds its beat and the engine waits
// to load the next; the input side keeps filling the queue until it is full.
// Reset (arst_n low) empties heap and queue and sets k_limit to 16.
// Write k_limit (cfg_we, cfg_data) only while the block is idle.
`default_nettype none

module top_k_min_heap_selector #(
	parameter int CAPACITY = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [tkh_pkg::KLIM_W-1:0] cfg_data,    // k_limit
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [tkh_pkg::DATA_W-1:0] s_tdata,     // doc_id[31:0], score[63:32]
	input  wire logic                       s_tuser,     // operation
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [tkh_pkg::DATA_W-1:0]      m_tdata,     // doc_id_res[31:0], score_res[63:32]
	output logic                            m_tuser,     // present
	output logic                            m_tlast      // last
);

	import tkh_pkg::*;

	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	res_t res;

	tkh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	tkh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	tkh_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// result beat: entry in tdata, present flag in tuser
	assign m_tdata = res.ent;
	assign m_tuser = res.present;
	assign m_tlast = res.last;

endmodule

`default_nettype wire

// File: tb/sv/tb_top_k_min_heap_selector.sv
// Self-checking testbench of the top-k min-heap selector: directed and random command streams.
`default_nettype none

module tb_top_k_min_heap_selector;

	import tkh_pkg::*;

	localparam int CAP         = 16;    // built capacity of the heap under test
	localparam int STALL_LIMIT = 5000;  // cycles with no beat moving on either side
	localparam int SETTLE      = 200;   // covers a full input backlog of pushes
	localparam int HOLD_CYCLES = 300;   // long output hold-off of the pressure test

	// ------------------------------------------------------------------
	// DUT signals; the inputs are driven to known values from time zero
	// ------------------------------------------------------------------
	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              cfg_we   = 1'b0;
	logic [KLIM_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;   // doc_id[31:0], score[63:32]
	logic              s_tuser  = 1'b0; // operation
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // doc_id_res[31:0], score_res[63:32]
	logic              m_tuser;         // present
	logic              m_tlast;         // last

	top_k_min_heap_selector #(
		.CAPACITY(CAP)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Heap predictor: its own copy of the kept entries and of k_limit
	// ------------------------------------------------------------------
	logic [31:0]        kept_doc[CAP];
	logic signed [31:0] kept_score[CAP];
	int                 kept_cnt = 0;
	logic [KLIM_W-1:0]  k_reg = KLIM_RESET;

	res_t ranked_out_q[$];   // result beats still owed by the block, oldest first

	int errors       = 0;
	int beats_in     = 0;
	int beats_out    = 0;
	int extracts     = 0;
	int src_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req     = 1'b0;
	int stall_cycles = 0;

	task automatic heap_swap(input int a, input int b);
		logic [31:0]        d;
		logic signed [31:0] s;
		d = kept_doc[a];
		kept_doc[a] = kept_doc[b];
		kept_doc[b] = d;
		s = kept_score[a];
		kept_score[a] = kept_score[b];
		kept_score[b] = s;
	endtask

	task automatic heap_rise(input int pos);
		int up;
		while (pos > 0) begin
			up = (pos - 1) / 2;
			if (kept_score[pos] < kept_score[up]) begin
				heap_swap(pos, up);
				pos = up;
			end else begin
				break;
			end
		end
	endtask

	task automatic heap_sink(input int pos, input int size);
		int l, r, m;
		while (pos < size) begin
			l = 2 * pos + 1;
			r = 2 * pos + 2;
			m = pos;
			if (l < size && kept_score[l] < kept_score[m])
				m = l;
			if (r < size && kept_score[r] < kept_score[m])
				m = r;
			if (m == pos)
				break;
			heap_swap(pos, m);
			pos = m;
		end
	endtask

	// Applies one accepted command; an extract queues its result beats.
	task automatic apply_command(input op_t op, input logic [31:0] doc,
	                             input logic signed [31:0] score);
		int   k_eff, n;
		res_t beat;
		res_t ascending[CAP];
		k_eff = (k_reg > CAP) ? CAP : int'(k_reg);
		if (op == OP_PUSH) begin
			if (kept_cnt < k_eff) begin
				kept_doc[kept_cnt] = doc;
				kept_score[kept_cnt] = score;
				kept_cnt++;
				heap_rise(kept_cnt - 1);
			end else if (kept_cnt > 0 && kept_score[0] < score) begin
				// full heap: only a strictly better score evicts the root
				kept_doc[0] = doc;
				kept_score[0] = score;
				heap_sink(0, kept_cnt);
			end
		end else begin
			extracts++;
			if (kept_cnt == 0) begin
				beat = '0;
				beat.last = 1'b1;
				ranked_out_q = {ranked_out_q, beat};
			end else begin
				// pop roots in ascending order, then owe them highest first
				n = 0;
				while (kept_cnt > 0) begin
					ascending[n].present = 1'b1;
					ascending[n].last = 1'b0;
					ascending[n].ent.doc = kept_doc[0];
					ascending[n].ent.score = kept_score[0];
					n++;
					kept_doc[0] = kept_doc[kept_cnt - 1];
					kept_score[0] = kept_score[kept_cnt - 1];
					kept_cnt--;
					heap_sink(0, kept_cnt);
				end
				for (int i = n - 1; i >= 0; i--) begin
					beat = ascending[i];
					beat.last = (i == 0);
					ranked_out_q = {ranked_out_q, beat};
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// One command beat; random gap first, inputs change on the falling edge.
	task automatic send_cmd(input op_t op, input logic [31:0] doc, input logic [31:0] score);
		int gap;
		@(negedge clk);
		gap = 0;
		while ($urandom_range(99) < src_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {score, doc};
		do
			@(posedge clk);
		while (!s_tready);
		apply_command(op, doc, score);
		beats_in++;
	endtask

	task automatic source_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Sender pause: nothing new offered until every owed beat has come out.
	task automatic wait_drain();
		source_idle();
		while (ranked_out_q.size() != 0)
			@(posedge clk);
	endtask

	// k_limit is written only with the block idle; pushes give no beat, so
	// a fixed settle covers any backlog still in the engine.
	task automatic write_k(input logic [KLIM_W-1:0] value);
		wait_drain();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		k_reg = value;
	endtask

	function automatic logic [31:0] rand_score();
		logic [31:0] s;
		case ($urandom_range(0, 3))
			0: s = $urandom;
			1: s = 32'((int'($urandom_range(0, 16)) - 8) * 65536);   // whole values, many ties
			2: begin
				case ($urandom_range(0, 3))
					0: s = 32'h7FFF_FFFF;
					1: s = 32'h8000_0000;
					2: s = 32'h0000_0000;
					default: s = 32'hFFFF_FFFF;
				endcase
			end
			default: s = 32'(int'($urandom_range(0, 255)) - 128);
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Output side: ready pattern with an optional long hold-off
	// ------------------------------------------------------------------
	always begin
		@(negedge clk);
		if (hold_req) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
		end
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	task automatic note_mismatch(input string field, input logic [31:0] want_v,
	                             input logic [31:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
	endtask

	// Every result beat against the oldest owed beat, field by field.
	always @(posedge clk) begin : check_beat
		res_t   want;
		entry_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			beats_out++;
			if (ranked_out_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, actual present %b doc %h score %h last %b",
				         $time, m_tuser, got.doc, got.score, m_tlast);
			end else begin
				want = ranked_out_q.pop_front();
				if (m_tuser !== want.present)
					note_mismatch("present", 32'(want.present), 32'(m_tuser));
				if (got.doc !== want.ent.doc)
					note_mismatch("doc_id_res", want.ent.doc, got.doc);
				if (got.score !== want.ent.score)
					note_mismatch("score_res", want.ent.score, got.score);
				if (m_tlast !== want.last)
					note_mismatch("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Extract on an empty heap; its doc and score fields must be ignored.
	task automatic test_empty_extract();
		send_cmd(OP_EXTRACT, 32'hFFFF_FFFF, 32'h8000_0000);
	endtask

	// Extreme doc ids and scores at the reset k_limit, plus a tie.
	task automatic test_score_extremes();
		send_cmd(OP_PUSH, 32'h0000_0000, 32'h7FFF_FFFF);
		send_cmd(OP_PUSH, 32'hFFFF_FFFF, 32'h8000_0000);
		send_cmd(OP_PUSH, 32'hA5A5_A5A5, 32'h0000_0000);
		send_cmd(OP_PUSH, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
		send_cmd(OP_PUSH, 32'h0000_0001, 32'h0000_0000);
		send_cmd(OP_EXTRACT, 32'h0, 32'h0);
	endtask

	// k_limit 0 keeps nothing: the push vanishes, the extract sees an empty heap.
	task automatic test_k_zero();
		write_k(7'd0);
		send_cmd(OP_PUSH, 32'h1234_5678, 32'h0001_0000);
		send_cmd(OP_EXTRACT, 32'h0, 32'h0);
	endtask

	// Single slot: a better score replaces, a tie does not.
	task automatic test_k_one();
		write_k(7'd1);
		send_cmd(OP_PUSH, 32'd11, 32'h0064_0000);
		send_cmd(OP_PUSH, 32'd12, 32'h00C8_0000);
		send_cmd(OP_PUSH, 32'd13, 32'h00C8_0000);
		send_cmd(OP_EXTRACT, 32'h0, 32'h0);
	endtask

	// k_limit lowered below the fill: nothing dropped, pushes can only replace the root.
	task automatic test_k_lowered();
		write_k(7'd4);
		for (int i = 1; i <= 4; i++)
			send_cmd(OP_PUSH, 32'(100 + i), 32'(i * 10 * 65536));
		write_k(7'd2);
		send_cmd(OP_PUSH, 32'd200, 32'h0005_0000);   // below root, ignored
		send_cmd(OP_PUSH, 32'd201, 32'h000A_0000);   // ties root, ignored
		send_cmd(OP_PUSH, 32'd202, 32'h0032_0000);   // evicts root
		send_cmd(OP_EXTRACT, 32'h0, 32'h0);
	endtask

	// Output held off while the sender keeps offering: queue fills, s_tready drops.
	task automatic test_backpressure();
		write_k(7'd16);
		src_idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 3; i++)
			send_cmd(OP_PUSH, $urandom, rand_score());
		send_cmd(OP_EXTRACT, $urandom, $urandom);
		for (int i = 0; i < 8; i++)
			send_cmd(OP_PUSH, $urandom, rand_score());
		wait_drain();
	endtask

	// Runs of pushes with random content, each closed by an extract.
	task automatic test_random_phase(input int n_cmds, input int src_pct, input int rcv_pct,
	                                 input logic [KLIM_W-1:0] k_value);
		int sent, run_len;
		write_k(k_value);
		src_idle_pct = src_pct;
		rcv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_cmds) begin
			run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 20);
			for (int i = 0; i < run_len; i++)
				send_cmd(OP_PUSH, $urandom, rand_score());
			send_cmd(OP_EXTRACT, $urandom, $urandom);
			sent += run_len + 1;
			if ($urandom_range(0, 3) == 0)
				wait_drain();
		end
	endtask

	initial begin
		src_idle_pct = 38;
		rcv_idle_pct = 85;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_extract();
		test_score_extremes();
		test_k_zero();
		test_k_one();
		test_k_lowered();
		test_backpressure();
		test_random_phase(32, 38, 85, 7'($urandom_range(2, 12)));
		test_random_phase(32, 85, 38, 7'd64);
		test_random_phase(40, 0, 0, 7'd127);

		wait_drain();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d commands (%0d extracts) and %0d result beats",
		         beats_in, extracts, beats_out);
		$display("k_limit from 0 to 127, ties, extreme scores, empty extracts, output hold-off");
		if (errors == 0 && ranked_out_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: top_k_min_heap_selector.f
sv/tkh_pkg.sv
sv/tkh_ram.sv
sv/tkh_queue.sv
sv/tkh_front.sv
sv/tkh_engine.sv
sv/top_k_min_heap_selector.sv
tb/sv/tb_top_k_min_heap_selector.sv
